// ----- design/vip_pkg.sv -----
// ---------------------------------------------------------------------------
// vip_pkg
// Shared types and constants for the vertices-inside-planes block.
// ---------------------------------------------------------------------------
`default_nettype none

package vip_pkg;

    localparam int MAX_PLANES   = 32;
    localparam int MAX_VERTICES = 256;
    localparam int PLANE_AW     = $clog2(MAX_PLANES);
    localparam int VERT_AW      = $clog2(MAX_VERTICES);
    localparam int PCNT_W       = $clog2(MAX_PLANES + 1);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);

    // widths of the solver datapath
    localparam int NUM_W = 55;
    localparam int DEN_W = 41;

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // configuration register indexes
    localparam logic CFG_PAR_EPS = 1'b0;
    localparam logic CFG_IN_EPS  = 1'b1;

    localparam logic [31:0] PAR_EPS_RST = 32'd429497;
    localparam logic [15:0] IN_EPS_RST  = 16'd0;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic [7:0]         vertex_index;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic [8:0]         vertex_count;
        logic [31:0]        plane_mask;
        logic [5:0]         plane_count;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] d;
    } plane_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

endpackage

`default_nettype wire

// ----- design/vip_plane_mem.sv -----
// ---------------------------------------------------------------------------
// vip_plane_mem
// Plane store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module vip_plane_mem import vip_pkg::*; (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [PLANE_AW-1:0] waddr,
    input  wire plane_t              wdata,
    input  wire logic                re,
    input  wire logic [PLANE_AW-1:0] raddr,
    output plane_t                   rdata
);

    plane_t plane_mem [MAX_PLANES];
    plane_t rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            plane_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= plane_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/vip_vertex_mem.sv -----
// ---------------------------------------------------------------------------
// vip_vertex_mem
// Vertex store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module vip_vertex_mem import vip_pkg::*; (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [VERT_AW-1:0] waddr,
    input  wire vertex_t            wdata,
    input  wire logic               re,
    input  wire logic [VERT_AW-1:0] raddr,
    output vertex_t                 rdata
);

    vertex_t vertex_mem [MAX_VERTICES];
    vertex_t rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            vertex_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= vertex_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/vip_div.sv -----
// ---------------------------------------------------------------------------
// vip_div
// Radix-2 restoring divider: -num/den in Q16.16, truncated, saturated.
// ---------------------------------------------------------------------------
`default_nettype none

module vip_div import vip_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [DEN_W-1:0] den,
    output logic                         done,
    output logic signed [31:0]           quo
);

    localparam int DVD_W = NUM_W + 16;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DVD_W-1:0] dvd_reg,   dvd_next;
    logic [DEN_W-1:0] dsr_reg,   dsr_next;
    logic [DEN_W:0]   rem_reg,   rem_next;
    logic [32:0]      q_reg,     q_next;
    logic             big_reg,   big_next;
    logic             neg_reg,   neg_next;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [32:0]      q_neg;

    // one quotient bit per cycle
    always_comb
    begin
        num_mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_mag   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        rem_sh    = {rem_reg[DEN_W-1:0], dvd_reg[DVD_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        big_next  = big_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = {num_mag, 16'd0};
            dsr_next  = den_mag;
            rem_next  = '0;
            q_next    = '0;
            big_next  = 1'b0;
            neg_next  = (num[NUM_W-1] == den[DEN_W-1]);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            big_next = big_reg | q_reg[32];
            q_next   = {q_reg[31:0], ge};
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        big_reg <= big_next;
        neg_reg <= neg_next;
    end

    // sign and saturation
    always_comb
    begin
        q_neg = -q_reg;
        if (neg_reg)
        begin
            if (big_reg || q_reg > 33'h0_8000_0000)
            begin
                quo = 32'sh8000_0000;
            end
            else
            begin
                quo = $signed(q_neg[31:0]);
            end
        end
        else
        begin
            if (big_reg || q_reg > 33'h0_7FFF_FFFF)
            begin
                quo = 32'sh7FFF_FFFF;
            end
            else
            begin
                quo = $signed(q_reg[31:0]);
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- design/vertices_inside_planes_top.sv -----
// ---------------------------------------------------------------------------
// vertices_inside_planes_top
// Convex region vertices from stored half-space planes.
// ---------------------------------------------------------------------------
// Request beats (req_valid/req_stall/req) load a plane, run the vertex
// search, read a stored vertex or clear both stores. Every request gives
// exactly one response beat (rsp_valid/rsp_stall/rsp) carrying the status,
// the vertex read, and the current vertex count, plane mask and plane count.
// Load and clear go straight to the response state; read passes through
// the vertex read state first. A run walks every plane triple through
// one shared set of three multiplier lanes and one radix-2 divider:
// parallel tests on each plane pair and triple, a division per axis for a
// solved triple, and an inside test against every loaded plane. The plane
// store's single read port sets the pace of the inside test.
// A new request is taken only while the sequencer is idle; a finished
// response waits in the output register while rsp_stall is high, and the
// next request may already be accepted behind it.
// Reset empties both stores and sets the tolerances to their defaults.
// Configuration writes (wr_en/wr_index/wr_data) are taken any cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vertices_inside_planes_top import vip_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp,
    input  wire logic        wr_en,
    input  wire logic        wr_index,
    input  wire logic [31:0] wr_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RDV  = 5'd1;
    localparam logic [4:0] S_RESP = 5'd2;
    localparam logic [4:0] S_NI   = 5'd3;
    localparam logic [4:0] S_LI   = 5'd4;
    localparam logic [4:0] S_NJ   = 5'd5;
    localparam logic [4:0] S_LJ   = 5'd6;
    localparam logic [4:0] S_NK   = 5'd7;
    localparam logic [4:0] S_LK   = 5'd8;
    localparam logic [4:0] S_XA   = 5'd9;
    localparam logic [4:0] S_XB   = 5'd10;
    localparam logic [4:0] S_XC   = 5'd11;
    localparam logic [4:0] S_LA   = 5'd12;
    localparam logic [4:0] S_LB   = 5'd13;
    localparam logic [4:0] S_QA   = 5'd14;
    localparam logic [4:0] S_QB   = 5'd15;
    localparam logic [4:0] S_QC   = 5'd16;
    localparam logic [4:0] S_NA   = 5'd17;
    localparam logic [4:0] S_NB   = 5'd18;
    localparam logic [4:0] S_DV   = 5'd19;
    localparam logic [4:0] S_IA   = 5'd20;
    localparam logic [4:0] S_IB   = 5'd21;
    localparam logic [4:0] S_IC   = 5'd22;
    localparam logic [4:0] S_KEEP = 5'd23;

    // which cross product is being formed
    localparam logic [1:0] XS_12 = 2'd0;
    localparam logic [1:0] XS_23 = 2'd1;
    localparam logic [1:0] XS_31 = 2'd2;

    localparam int ROT1 [3] = '{1, 2, 0};
    localparam int ROT2 [3] = '{2, 0, 1};

    // control state
    logic [4:0]        state_reg,   state_next;
    logic [PCNT_W-1:0] pl_reg,      pl_next;
    logic [VCNT_W-1:0] vf_reg,      vf_next;
    logic [31:0]       mask_reg,    mask_next;
    logic              ovf_reg,     ovf_next;
    logic              rspv_reg,    rspv_next;
    logic [31:0]       par_eps_reg, par_eps_next;
    logic [15:0]       in_eps_reg,  in_eps_next;

    // datapath state
    logic [PCNT_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next, l_reg, l_next;
    logic [1:0]         xsel_reg, xsel_next;
    logic [1:0]         ax_reg, ax_next;
    logic signed [31:0] n1_reg [3], n1_next [3];
    logic signed [31:0] n2_reg [3], n2_next [3];
    logic signed [31:0] n3_reg [3], n3_next [3];
    logic signed [31:0] d1_reg, d1_next, d2_reg, d2_next, d3_reg, d3_next;
    logic signed [32:0] c12_reg [3], c12_next [3];
    logic signed [32:0] c23_reg [3], c23_next [3];
    logic signed [32:0] c31_reg [3], c31_next [3];
    logic signed [32:0] cx_reg [3], cx_next [3];
    logic signed [32:0] hi_reg [3], hi_next [3];
    logic signed [40:0] q_reg, q_next;
    logic signed [31:0] v_reg [3], v_next [3];
    logic signed [31:0] dl_reg, dl_next;
    logic signed [65:0] prod_reg [3];
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] res_reg [3], res_next [3];
    rsp_t               rsp_reg, rsp_next;

    // multiplier lane operands
    logic signed [32:0] opa [3];
    logic signed [32:0] opb [3];
    logic signed [31:0] xa [3];
    logic signed [31:0] xb [3];
    logic signed [31:0] pn [3];

    // memory ports
    logic                pm_we, pm_re;
    logic [PLANE_AW-1:0] pm_waddr, pm_raddr;
    plane_t              pm_wdata, pm_rdata;
    logic                vm_we, vm_re;
    logic [VERT_AW-1:0]  vm_waddr, vm_raddr;
    vertex_t             vm_wdata, vm_rdata;

    // divider
    logic                    dv_start, dv_done;
    logic signed [NUM_W-1:0] dv_num;
    logic signed [31:0]      dv_quo;

    // combine terms
    logic [42:0]         len_sum;
    logic signed [40:0]  q_sum;
    logic [40:0]         q_mag;
    logic signed [35:0]  dot;
    logic                acc;

    vip_plane_mem u_plane_mem (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .re    (pm_re),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    vip_vertex_mem u_vertex_mem (
        .clk   (clk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .re    (vm_re),
        .raddr (vm_raddr),
        .rdata (vm_rdata)
    );

    vip_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (q_reg),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign acc       = req_valid && (state_reg == S_IDLE);

    // cross product operand selection
    always_comb
    begin
        pn[0] = pm_rdata.nx;
        pn[1] = pm_rdata.ny;
        pn[2] = pm_rdata.nz;
        for (int m = 0; m < 3; m++)
        begin
            unique case (xsel_reg)
                XS_12:
                begin
                    xa[m] = n1_reg[m];
                    xb[m] = n2_reg[m];
                end
                XS_23:
                begin
                    xa[m] = n2_reg[m];
                    xb[m] = n3_reg[m];
                end
                default:
                begin
                    xa[m] = n3_reg[m];
                    xb[m] = n1_reg[m];
                end
            endcase
        end
    end

    // multiplier lane operands by step
    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            opa[m] = '0;
            opb[m] = '0;
        end
        unique case (state_reg)
            S_XA:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    opa[m] = 33'(xa[ROT1[m]]);
                    opb[m] = 33'(xb[ROT2[m]]);
                end
            end
            S_XB:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    opa[m] = 33'(xa[ROT2[m]]);
                    opb[m] = 33'(xb[ROT1[m]]);
                end
            end
            S_LA:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    opa[m] = cx_reg[m] >>> 12;
                    opb[m] = cx_reg[m] >>> 12;
                end
            end
            S_QA:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    opa[m] = 33'(n1_reg[m]);
                    opb[m] = c23_reg[m];
                end
            end
            S_NA:
            begin
                opa[0] = c23_reg[ax_reg];
                opb[0] = 33'(d1_reg);
                opa[1] = c31_reg[ax_reg];
                opb[1] = 33'(d2_reg);
                opa[2] = c12_reg[ax_reg];
                opb[2] = 33'(d3_reg);
            end
            S_IB:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    opa[m] = 33'(pn[m]);
                    opb[m] = 33'(v_reg[m]);
                end
            end
            default:
            begin
            end
        endcase
    end

    // lane products, registered
    always_ff @(posedge clk)
    begin
        for (int m = 0; m < 3; m++)
        begin
            prod_reg[m] <= opa[m] * opb[m];
        end
    end

    // sums over the lanes
    always_comb
    begin
        len_sum = prod_reg[0][42:0] + prod_reg[1][42:0] + prod_reg[2][42:0];
        q_sum   = 41'($signed(prod_reg[0][64:26])) + 41'($signed(prod_reg[1][64:26]))
                + 41'($signed(prod_reg[2][64:26]));
        q_mag   = q_reg[40] ? 41'(-q_reg) : 41'(q_reg);
        dv_num  = NUM_W'($signed(prod_reg[0][64:12])) + NUM_W'($signed(prod_reg[1][64:12]))
                + NUM_W'($signed(prod_reg[2][64:12]));
        dot     = 36'($signed(prod_reg[0][63:30])) + 36'($signed(prod_reg[1][63:30]))
                + 36'($signed(prod_reg[2][63:30])) + 36'(dl_reg);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        pl_next      = pl_reg;
        vf_next      = vf_reg;
        mask_next    = mask_reg;
        ovf_next     = ovf_reg;
        rspv_next    = rspv_reg;
        par_eps_next = par_eps_reg;
        in_eps_next  = in_eps_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        xsel_next    = xsel_reg;
        ax_next      = ax_reg;
        n1_next      = n1_reg;
        n2_next      = n2_reg;
        n3_next      = n3_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        d3_next      = d3_reg;
        c12_next     = c12_reg;
        c23_next     = c23_reg;
        c31_next     = c31_reg;
        cx_next      = cx_reg;
        hi_next      = hi_reg;
        q_next       = q_reg;
        v_next       = v_reg;
        dl_next      = dl_reg;
        status_next  = status_reg;
        res_next     = res_reg;
        rsp_next     = rsp_reg;
        pm_we        = 1'b0;
        pm_waddr     = pl_reg[PLANE_AW-1:0];
        pm_wdata     = '{nx: req.normal_x, ny: req.normal_y, nz: req.normal_z,
                         d: req.plane_offset};
        pm_re        = 1'b0;
        pm_raddr     = i_reg[PLANE_AW-1:0];
        vm_we        = 1'b0;
        vm_waddr     = vf_reg[VERT_AW-1:0];
        vm_wdata     = '{x: v_reg[0], y: v_reg[1], z: v_reg[2]};
        vm_re        = 1'b0;
        vm_raddr     = req.vertex_index;
        dv_start     = 1'b0;

        // configuration writes
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_PAR_EPS: par_eps_next = wr_data;
                CFG_IN_EPS:  in_eps_next  = wr_data[15:0];
            endcase
        end

        // output register drains
        if (rspv_reg && !rsp_stall)
        begin
            rspv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    for (int m = 0; m < 3; m++)
                    begin
                        res_next[m] = '0;
                    end
                    status_next = ST_OK;
                    unique case (req.req_type)
                        REQ_LOAD:
                        begin
                            if (pl_reg < PCNT_W'(MAX_PLANES))
                            begin
                                pm_we   = 1'b1;
                                pl_next = pl_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                            state_next = S_RESP;
                        end
                        REQ_RUN:
                        begin
                            vf_next    = '0;
                            mask_next  = '0;
                            ovf_next   = 1'b0;
                            i_next     = '0;
                            state_next = S_NI;
                        end
                        REQ_READ:
                        begin
                            vm_re = 1'b1;
                            if ({1'b0, req.vertex_index} >= vf_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            state_next = S_RDV;
                        end
                        REQ_CLEAR:
                        begin
                            pl_next    = '0;
                            vf_next    = '0;
                            mask_next  = '0;
                            ovf_next   = 1'b0;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RDV:
            begin
                if (status_reg == ST_OK)
                begin
                    res_next[0] = vm_rdata.x;
                    res_next[1] = vm_rdata.y;
                    res_next[2] = vm_rdata.z;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rspv_reg || !rsp_stall)
                begin
                    rsp_next.status       = status_reg;
                    rsp_next.vertex_x     = res_reg[0];
                    rsp_next.vertex_y     = res_reg[1];
                    rsp_next.vertex_z     = res_reg[2];
                    rsp_next.vertex_count = 9'(vf_reg);
                    rsp_next.plane_mask   = mask_reg;
                    rsp_next.plane_count  = 6'(pl_reg);
                    rspv_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            // first plane of a triple
            S_NI:
            begin
                if (i_reg < pl_reg)
                begin
                    pm_re      = 1'b1;
                    pm_raddr   = i_reg[PLANE_AW-1:0];
                    state_next = S_LI;
                end
                else
                begin
                    status_next = ovf_reg ? ST_OVF : ST_OK;
                    state_next  = S_RESP;
                end
            end
            S_LI:
            begin
                n1_next    = pn;
                d1_next    = pm_rdata.d;
                j_next     = i_reg + 1'b1;
                state_next = S_NJ;
            end
            // second plane
            S_NJ:
            begin
                if (j_reg < pl_reg)
                begin
                    pm_re      = 1'b1;
                    pm_raddr   = j_reg[PLANE_AW-1:0];
                    state_next = S_LJ;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_NI;
                end
            end
            S_LJ:
            begin
                n2_next    = pn;
                d2_next    = pm_rdata.d;
                xsel_next  = XS_12;
                state_next = S_XA;
            end
            // third plane
            S_NK:
            begin
                if (k_reg < pl_reg)
                begin
                    pm_re      = 1'b1;
                    pm_raddr   = k_reg[PLANE_AW-1:0];
                    state_next = S_LK;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_NJ;
                end
            end
            S_LK:
            begin
                n3_next    = pn;
                d3_next    = pm_rdata.d;
                xsel_next  = XS_23;
                state_next = S_XA;
            end
            // cross product in two multiply passes
            S_XA:
            begin
                state_next = S_XB;
            end
            S_XB:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    hi_next[m] = 33'($signed(prod_reg[m][63:32]));
                end
                state_next = S_XC;
            end
            S_XC:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    cx_next[m] = hi_reg[m] - 33'($signed(prod_reg[m][63:32]));
                end
                unique case (xsel_reg)
                    XS_12:   c12_next = cx_next;
                    XS_23:   c23_next = cx_next;
                    default: c31_next = cx_next;
                endcase
                state_next = S_LA;
            end
            // length squared test
            S_LA:
            begin
                state_next = S_LB;
            end
            S_LB:
            begin
                if (len_sum > 43'(par_eps_reg))
                begin
                    unique case (xsel_reg)
                        XS_12:
                        begin
                            k_next     = j_reg + 1'b1;
                            state_next = S_NK;
                        end
                        XS_23:
                        begin
                            xsel_next  = XS_31;
                            state_next = S_XA;
                        end
                        default:
                        begin
                            state_next = S_QA;
                        end
                    endcase
                end
                else if (xsel_reg == XS_12)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_NJ;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_NK;
                end
            end
            // triple product
            S_QA:
            begin
                state_next = S_QB;
            end
            S_QB:
            begin
                q_next     = q_sum;
                state_next = S_QC;
            end
            S_QC:
            begin
                if (q_mag > 41'(par_eps_reg))
                begin
                    ax_next    = '0;
                    state_next = S_NA;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_NK;
                end
            end
            // numerator and division, one axis at a time
            S_NA:
            begin
                state_next = S_NB;
            end
            S_NB:
            begin
                dv_start   = 1'b1;
                state_next = S_DV;
            end
            S_DV:
            begin
                if (dv_done)
                begin
                    v_next[ax_reg] = dv_quo;
                    if (ax_reg == 2'd2)
                    begin
                        l_next     = '0;
                        state_next = S_IA;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = S_NA;
                    end
                end
            end
            // inside test against every loaded plane
            S_IA:
            begin
                if (l_reg < pl_reg)
                begin
                    pm_re      = 1'b1;
                    pm_raddr   = l_reg[PLANE_AW-1:0];
                    state_next = S_IB;
                end
                else
                begin
                    state_next = S_KEEP;
                end
            end
            S_IB:
            begin
                dl_next    = pm_rdata.d;
                state_next = S_IC;
            end
            S_IC:
            begin
                if (dot > $signed(36'(in_eps_reg)))
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_NK;
                end
                else
                begin
                    l_next     = l_reg + 1'b1;
                    state_next = S_IA;
                end
            end
            // store the vertex and mark its planes
            S_KEEP:
            begin
                if (vf_reg < VCNT_W'(MAX_VERTICES))
                begin
                    vm_we   = 1'b1;
                    vf_next = vf_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                mask_next[i_reg[PLANE_AW-1:0]] = 1'b1;
                mask_next[j_reg[PLANE_AW-1:0]] = 1'b1;
                mask_next[k_reg[PLANE_AW-1:0]] = 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = S_NK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pl_reg      <= '0;
            vf_reg      <= '0;
            mask_reg    <= '0;
            ovf_reg     <= 1'b0;
            rspv_reg    <= 1'b0;
            par_eps_reg <= PAR_EPS_RST;
            in_eps_reg  <= IN_EPS_RST;
        end
        else
        begin
            state_reg   <= state_next;
            pl_reg      <= pl_next;
            vf_reg      <= vf_next;
            mask_reg    <= mask_next;
            ovf_reg     <= ovf_next;
            rspv_reg    <= rspv_next;
            par_eps_reg <= par_eps_next;
            in_eps_reg  <= in_eps_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        l_reg      <= l_next;
        xsel_reg   <= xsel_next;
        ax_reg     <= ax_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        n3_reg     <= n3_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        d3_reg     <= d3_next;
        c12_reg    <= c12_next;
        c23_reg    <= c23_next;
        c31_reg    <= c31_next;
        cx_reg     <= cx_next;
        hi_reg     <= hi_next;
        q_reg      <= q_next;
        v_reg      <= v_next;
        dl_reg     <= dl_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rspv_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
